[design/poptrie_route_lookup_top_macros.svh]
// ----------------------------------------------------------------------------
// poptrie route lookup assertion macros
// shared concurrent check forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef POPTRIE_ROUTE_LOOKUP_TOP_MACROS_SVH
`define POPTRIE_ROUTE_LOOKUP_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PRL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds at every edge
`define PRL_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

[design/prl_pkg.sv]
// ----------------------------------------------------------------------------
// prl_pkg
// types, constants and helper functions for the poptrie route lookup block
// ----------------------------------------------------------------------------
package prl_pkg;

	// default store geometry
	localparam int DIRECT_BITS_DEF  = 12;
	localparam int NODE_ENTRIES_DEF = 4096;
	localparam int LEAF_ENTRIES_DEF = 65536;

	// address and stride geometry
	localparam int ADDR_W     = 32;
	localparam int STRIDE     = 6;
	localparam int STRIDE_TOP = ADDR_W - STRIDE;
	localparam int MAP_W      = 64;
	localparam int CNT_W      = 7;

	// node record: child bitmap, leaf bitmap, child base, leaf base (low to high)
	localparam int CBASE_W    = 12;
	localparam int LBASE_W    = 16;
	localparam int NODE_REC_W = 2 * MAP_W + CBASE_W + LBASE_W;

	// direct entry: target in the low 16 bits, leaf flag above
	localparam int TARGET_W = 16;
	localparam int DIR_W    = TARGET_W + 1;

	// stream widths
	localparam int OP_W       = 2;
	localparam int IN_DATA_W  = 256;
	localparam int OUT_DATA_W = 40;
	localparam int PORT_W     = 32;

	localparam logic [PORT_W-1:0] NO_ROUTE = '1;

	// item kinds carried in tuser
	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_DIRECT = 2'd1,
		OP_NODE   = 2'd2,
		OP_LEAF   = 2'd3
	} op_t;

	// one input transaction as it travels the pipeline
	typedef struct packed {
		op_t                 op;
		logic [ADDR_W-1:0]   address;
		logic [15:0]         entry_index;
		logic                direct_is_leaf;
		logic [TARGET_W-1:0] direct_target;
		logic [MAP_W-1:0]    child_bitmap;
		logic [MAP_W-1:0]    leaf_bitmap;
		logic [LBASE_W-1:0]  leaf_base;
		logic [CBASE_W-1:0]  child_base;
		logic [PORT_W-1:0]   port_value;
	} req_t;

	// six-bit stride value at a bit position, zero padded past bit 31
	function automatic logic [STRIDE-1:0] stride_at(logic [ADDR_W-1:0] addr, int pos);
		logic [ADDR_W-1:0] t;
		t = '0;
		if (pos >= ADDR_W) begin
			t = '0;
		end else if (pos <= STRIDE_TOP) begin
			t = addr >> (STRIDE_TOP - pos);
		end else begin
			t = addr << (pos - STRIDE_TOP);
		end
		return t[STRIDE-1:0];
	endfunction

	// popcount of bitmap bits at or below v
	function automatic logic [CNT_W-1:0] ones_upto(logic [MAP_W-1:0] map, logic [STRIDE-1:0] v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < MAP_W; i++) begin
			if (map[i] && (STRIDE'(i) <= v)) begin
				n = n + CNT_W'(1);
			end
		end
		return n;
	endfunction

	// x modulo a constant store size, x below 2^17 and m at least 64;
	// a power-of-two size folds to a mask, others to a restoring subtract chain
	function automatic logic [31:0] mod_const(logic [31:0] x, logic [31:0] m);
		logic [31:0] r;
		r = x;
		if ((m & (m - 32'd1)) == 32'd0) begin
			r = x & (m - 32'd1);
		end else begin
			for (int j = 10; j >= 0; j--) begin
				if (r >= (m << j)) begin
					r = r - (m << j);
				end
			end
		end
		return r;
	endfunction

	// (s - 1) modulo m, with zero wrapping to the last entry
	function automatic logic [31:0] minus_one_mod(logic [16:0] s, logic [31:0] m);
		logic [31:0] r;
		if (s == 17'd0) begin
			r = m - 32'd1;
		end else begin
			r = mod_const(32'(s) - 32'd1, m);
		end
		return r;
	endfunction

endpackage

[design/poptrie_route_lookup_top.sv]
// ----------------------------------------------------------------------------
// poptrie route lookup
// pipelined ipv4 longest prefix match over a direct table, node and leaf stores
// ----------------------------------------------------------------------------
// Usage:
// The slave channel (s_tvalid/s_tready/s_tdata/s_tuser) takes one transaction
// per item: tuser holds the kind (lookup, direct write, node write, leaf
// write), tdata the address and write fields. Each lookup gives one result on
// the master channel (m_tvalid/m_tready/m_tdata) with the port and a found
// flag; writes give no result. Stores are written by software before lookups
// read them, and writes take effect in order with lookups around them.
// A lookup passes the direct table read, the direct index reduction, NLEV
// node levels and the leaf read, NLEV being one node level per stride below
// bit 32 plus a final leaf level. Each level is a node read, a popcount and
// add, and an index reduction, each with its own copy of the node store.
// Throughput is one transaction per cycle. When m_tready is low each stage
// holds its item and bubbles close up; s_tready falls only once every stage
// is full. Reset clears the stage valid bits only; the stores keep no reset.
// ----------------------------------------------------------------------------
`include "poptrie_route_lookup_top_macros.svh"

module poptrie_route_lookup_top #(
	parameter int DIRECT_BITS  = prl_pkg::DIRECT_BITS_DEF,
	parameter int NODE_ENTRIES = prl_pkg::NODE_ENTRIES_DEF,
	parameter int LEAF_ENTRIES = prl_pkg::LEAF_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// address, entry_index, direct_is_leaf, direct_target, child_bitmap,
	// leaf_bitmap, leaf_base, child_base, port_value, zero fill
	input  logic [prl_pkg::IN_DATA_W-1:0]  s_tdata,
	// op
	input  logic [prl_pkg::OP_W-1:0]       s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// port, route_found, zero fill
	output logic [prl_pkg::OUT_DATA_W-1:0] m_tdata
);
	import prl_pkg::*;

	localparam int NODE_W    = $clog2(NODE_ENTRIES);
	localparam int LEAF_W    = $clog2(LEAF_ENTRIES);
	localparam int DIR_DEPTH = 1 << DIRECT_BITS;
	localparam int NWALK     = (ADDR_W - DIRECT_BITS + STRIDE - 1) / STRIDE;
	localparam int NLEV      = NWALK + 1;
	localparam int NSTG      = 3 * NLEV + 3;
	localparam int ST_LEAF   = NSTG - 1;
	localparam int ST_LAST_C = ST_LEAF - 1;

	// flow control
	logic [NSTG-1:0] valid_s;
	logic [NSTG-1:0] vin;
	logic [NSTG-1:0] adv;
	logic [NSTG-1:0] ld;
	req_t            in_req;
	req_t            req_s [NSTG-1];

	// direct and walk state
	logic [DIR_W-1:0]      dir_rd_s1;
	logic                  act_s2;
	logic [NODE_W-1:0]     nd_s2;
	logic [LEAF_W-1:0]     li_s2;
	logic [31:0]           dir_nd_mod;
	logic [31:0]           dir_li_mod;
	logic [NODE_REC_W-1:0] node_rd_sa [NLEV];
	logic                  act_sa [NLEV];
	logic [LEAF_W-1:0]     li_sa [NLEV];
	logic                  act_sb [NLEV];
	logic                  desc_sb [NLEV];
	logic [12:0]           nsum_sb [NLEV];
	logic [16:0]           lsum_sb [NLEV];
	logic [LEAF_W-1:0]     li_sb [NLEV];
	logic                  act_sc [NLEV];
	logic [NODE_W-1:0]     nd_sc [NLEV];
	logic [LEAF_W-1:0]     li_sc [NLEV];
	logic [PORT_W-1:0]     port_so;

	// unpack the input transaction
	always_comb begin
		in_req.op             = op_t'(s_tuser);
		in_req.address        = s_tdata[31:0];
		in_req.entry_index    = s_tdata[47:32];
		in_req.direct_is_leaf = s_tdata[48];
		in_req.direct_target  = s_tdata[64:49];
		in_req.child_bitmap   = s_tdata[128:65];
		in_req.leaf_bitmap    = s_tdata[192:129];
		in_req.leaf_base      = s_tdata[208:193];
		in_req.child_base     = s_tdata[220:209];
		in_req.port_value     = s_tdata[252:221];
	end

	// per-stage advance: a stage loads when empty or when the next one loads
	always_comb begin
		vin = {valid_s[NSTG-2:0], s_tvalid};
		adv[NSTG-1] = !valid_s[NSTG-1] || m_tready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			adv[i] = !valid_s[i] || adv[i+1];
		end
		ld = adv & vin;
	end

	assign s_tready = adv[0];

	// stage valid bits; only lookups reach the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int i = 0; i < NSTG - 1; i++) begin
				if (adv[i]) begin
					valid_s[i] <= vin[i];
				end
			end
			if (adv[ST_LEAF]) begin
				valid_s[ST_LEAF] <= vin[ST_LEAF] && (req_s[ST_LEAF-1].op == OP_LOOKUP);
			end
		end
	end

	// transaction payload travels with the valid bits
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			req_s[0] <= in_req;
		end
		for (int i = 1; i < NSTG - 1; i++) begin
			if (adv[i]) begin
				req_s[i] <= req_s[i-1];
			end
		end
	end

	// direct table: written and read at the entry stage
	logic [DIR_W-1:0] dir_mem [DIR_DEPTH];
	logic [31:0]      dir_widx;

	assign dir_widx = 32'(in_req.entry_index);

	always_ff @(posedge clk) begin
		if (ld[0] && (in_req.op == OP_DIRECT)) begin
			dir_mem[dir_widx[DIRECT_BITS-1:0]] <= {in_req.direct_is_leaf, in_req.direct_target};
		end
		if (adv[0]) begin
			dir_rd_s1 <= dir_mem[in_req.address[ADDR_W-1 -: DIRECT_BITS]];
		end
	end

	// reduce the direct target to a node or leaf index
	always_comb begin
		dir_nd_mod = mod_const(32'(dir_rd_s1[TARGET_W-1:0]), 32'(NODE_ENTRIES));
		dir_li_mod = mod_const(32'(dir_rd_s1[TARGET_W-1:0]), 32'(LEAF_ENTRIES));
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			act_s2 <= (req_s[0].op == OP_LOOKUP) && !dir_rd_s1[TARGET_W];
			nd_s2  <= dir_nd_mod[NODE_W-1:0];
			li_s2  <= dir_li_mod[LEAF_W-1:0];
		end
	end

	// node levels: read, count, reduce
	for (genvar k = 0; k < NLEV; k++) begin : g_lvl
		localparam int SA  = 2 + 3 * k;
		localparam int SB  = SA + 1;
		localparam int SC  = SA + 2;
		localparam int POS = DIRECT_BITS + STRIDE * k;

		logic                  act_in;
		logic [NODE_W-1:0]     nd_in;
		logic [LEAF_W-1:0]     li_in;
		logic [NODE_REC_W-1:0] node_mem [NODE_ENTRIES];
		logic [NODE_REC_W-1:0] wrec;
		logic                  wr_en;
		logic [STRIDE-1:0]     v;
		logic [CNT_W-1:0]      cnt_c;
		logic [CNT_W-1:0]      cnt_l;
		logic [31:0]           red_nd;
		logic [31:0]           red_li;

		if (k == 0) begin : g_first
			assign act_in = act_s2;
			assign nd_in  = nd_s2;
			assign li_in  = li_s2;
		end else begin : g_next
			assign act_in = act_sc[k-1];
			assign nd_in  = nd_sc[k-1];
			assign li_in  = li_sc[k-1];
		end

		// node store copy for this level, written as the write passes by
		assign wrec  = {req_s[SA-1].leaf_base, req_s[SA-1].child_base,
			req_s[SA-1].leaf_bitmap, req_s[SA-1].child_bitmap};
		assign wr_en = ld[SA] && (req_s[SA-1].op == OP_NODE) &&
			(32'(req_s[SA-1].entry_index) < 32'(NODE_ENTRIES));

		always_ff @(posedge clk) begin
			if (wr_en) begin
				node_mem[req_s[SA-1].entry_index[NODE_W-1:0]] <= wrec;
			end
			if (adv[SA]) begin
				node_rd_sa[k] <= node_mem[nd_in];
				act_sa[k]     <= act_in;
				li_sa[k]      <= li_in;
			end
		end

		// stride value and bitmap counts
		always_comb begin
			v     = stride_at(req_s[SA].address, POS);
			cnt_c = ones_upto(node_rd_sa[k][MAP_W-1:0], v);
			cnt_l = ones_upto(node_rd_sa[k][2*MAP_W-1:MAP_W], v);
		end

		always_ff @(posedge clk) begin
			if (adv[SB]) begin
				act_sb[k]  <= act_sa[k];
				desc_sb[k] <= act_sa[k] && (POS < ADDR_W) && node_rd_sa[k][v];
				nsum_sb[k] <= {1'b0, node_rd_sa[k][2*MAP_W +: CBASE_W]} + 13'(cnt_c);
				lsum_sb[k] <= {1'b0, node_rd_sa[k][2*MAP_W+CBASE_W +: LBASE_W]} + 17'(cnt_l);
				li_sb[k]   <= li_sa[k];
			end
		end

		// base plus count minus one, taken modulo the store size
		always_comb begin
			red_nd = minus_one_mod(17'(nsum_sb[k]), 32'(NODE_ENTRIES));
			red_li = minus_one_mod(lsum_sb[k], 32'(LEAF_ENTRIES));
		end

		always_ff @(posedge clk) begin
			if (adv[SC]) begin
				act_sc[k] <= act_sb[k] && desc_sb[k];
				nd_sc[k]  <= red_nd[NODE_W-1:0];
				li_sc[k]  <= (act_sb[k] && !desc_sb[k]) ? red_li[LEAF_W-1:0] : li_sb[k];
			end
		end
	end

	// leaf store and output register
	logic [PORT_W-1:0] leaf_mem [LEAF_ENTRIES];
	logic [31:0]       leaf_widx;
	logic              leaf_wr;

	assign leaf_widx = 32'(req_s[ST_LEAF-1].entry_index);
	assign leaf_wr   = ld[ST_LEAF] && (req_s[ST_LEAF-1].op == OP_LEAF) &&
		(leaf_widx < 32'(LEAF_ENTRIES));

	always_ff @(posedge clk) begin
		if (leaf_wr) begin
			leaf_mem[leaf_widx[LEAF_W-1:0]] <= req_s[ST_LEAF-1].port_value;
		end
		if (adv[ST_LEAF]) begin
			port_so <= leaf_mem[li_sc[NLEV-1]];
		end
	end

	// result transaction
	assign m_tvalid = valid_s[ST_LEAF];
	assign m_tdata  = {(OUT_DATA_W - PORT_W - 1)'(0), (port_so != NO_ROUTE), port_so};

	// checks
	`PRL_ASSERT_IMPL(a_full_when_blocked, !s_tready, &valid_s,
		"input blocked while a pipeline stage is empty")
	`PRL_ASSERT_IMPL(a_result_from_lookup, $rose(m_tvalid),
		$past(valid_s[ST_LEAF-1] && (req_s[ST_LEAF-1].op == OP_LOOKUP)),
		"result raised without a lookup leaving the walk")
	`PRL_ASSERT_ALWAYS(a_walk_ends, !valid_s[ST_LAST_C] || !act_sc[NLEV-1],
		"walk still active after the last node level")
	`PRL_ASSERT_IMPL(a_walk_only_lookup, valid_s[2] && act_sa[0],
		req_s[2].op == OP_LOOKUP, "node walk started by a write transaction")

endmodule

[sim/poptrie_route_lookup_top_tb.sv]
// ----------------------------------------------------------------------------
// poptrie route lookup testbench
// loads the direct, node and leaf stores through the slave stream amid
// lookups checked in order against fixed values or a route walk over a
// shadow copy of the stores; random gaps and stalls on both streams
// ----------------------------------------------------------------------------
module poptrie_route_lookup_top_tb;
	import prl_pkg::*;

	localparam int NODES  = NODE_ENTRIES_DEF;
	localparam int LEAVES = LEAF_ENTRIES_DEF;

	// one expected lookup answer
	typedef struct {
		logic [PORT_W-1:0] port;
		logic              found;
	} route_t;

	// one row of the opening stimulus
	typedef struct {
		req_t              item;
		bit                fixed;
		logic [PORT_W-1:0] want;
	} opening_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	// shadow stores and written marks
	logic [DIR_W-1:0]   dir_store [1 << DIRECT_BITS_DEF];
	logic [MAP_W-1:0]   child_maps [NODES];
	logic [MAP_W-1:0]   leaf_maps [NODES];
	logic [CBASE_W-1:0] child_bases [NODES];
	logic [LBASE_W-1:0] leaf_bases [NODES];
	logic [PORT_W-1:0]  leaf_store [LEAVES];
	bit                 dir_written [1 << DIRECT_BITS_DEF];
	bit                 node_written [NODES];
	bit                 leaf_written [LEAVES];

	route_t       route_q [$];
	opening_row_t opening_rows [$];
	int           mismatches;
	int           item_count;
	int           long_hold;
	bit           sender_gaps;

	poptrie_route_lookup_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#(12 * 500000);
		$display("Mismatches found");
		$finish;
	end

	function automatic void note_mismatch(string what, logic [PORT_W-1:0] want,
			logic [PORT_W-1:0] got);
		if (mismatches < 10) begin
			$display("mismatch %s: expected %h, got %h", what, want, got);
		end
		mismatches++;
	endfunction

	// walk the shadow trie for one address; returns OP_LOOKUP with the port
	// when every entry on the path is written, else the store of the first
	// unwritten entry and its index
	function automatic op_t walk_route(input logic [ADDR_W-1:0] addr,
			output logic [PORT_W-1:0] port, output logic [15:0] miss_idx);
		logic [DIR_W-1:0]   d;
		logic [CBASE_W-1:0] nd;
		logic [15:0]        li;
		logic [37:0]        ext;
		logic [5:0]         v;
		int                 pos;
		int                 cnt;
		port = NO_ROUTE;
		miss_idx = '0;
		ext = {addr, 6'b0};
		if (!dir_written[addr[31:20]]) begin
			miss_idx = 16'(addr[31:20]);
			return OP_DIRECT;
		end
		d = dir_store[addr[31:20]];
		if (d[TARGET_W]) begin
			li = d[TARGET_W-1:0];
		end else begin
			nd = d[CBASE_W-1:0];
			if (!node_written[nd]) begin
				miss_idx = 16'(nd);
				return OP_NODE;
			end
			pos = 12;
			v = ext[25 -: 6];
			// descend while the stride still holds address bits
			while (pos < 32 && child_maps[nd][v]) begin
				cnt = $countones(child_maps[nd] & (64'hFFFF_FFFF_FFFF_FFFF >> (63 - v)));
				nd = child_bases[nd] + 12'(cnt) - 12'd1;
				if (!node_written[nd]) begin
					miss_idx = 16'(nd);
					return OP_NODE;
				end
				pos += 6;
				v = (pos < 32) ? ext[37 - pos -: 6] : 6'd0;
			end
			cnt = $countones(leaf_maps[nd] & (64'hFFFF_FFFF_FFFF_FFFF >> (63 - v)));
			li = leaf_bases[nd] + 16'(cnt) - 16'd1;
		end
		if (!leaf_written[li]) begin
			miss_idx = li;
			return OP_LEAF;
		end
		port = leaf_store[li];
		return OP_LOOKUP;
	endfunction

	// store writes as the block applies them
	function automatic void apply_write(req_t it);
		logic [$clog2(NODES)-1:0] ni;
		ni = it.entry_index[$clog2(NODES)-1:0];
		case (it.op)
			OP_DIRECT: begin
				dir_store[it.entry_index[DIRECT_BITS_DEF-1:0]] = {it.direct_is_leaf,
					it.direct_target};
				dir_written[it.entry_index[DIRECT_BITS_DEF-1:0]] = 1'b1;
			end
			OP_NODE: begin
				if (it.entry_index < NODES) begin
					child_maps[ni] = it.child_bitmap;
					leaf_maps[ni] = it.leaf_bitmap;
					child_bases[ni] = it.child_base;
					leaf_bases[ni] = it.leaf_base;
					node_written[ni] = 1'b1;
				end
			end
			OP_LEAF: begin
				leaf_store[it.entry_index] = it.port_value;
				leaf_written[it.entry_index] = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// item with every field random, so unused fields toggle too
	function automatic req_t noise_item(op_t op);
		req_t r;
		r.op = op;
		r.address = $urandom;
		r.entry_index = 16'($urandom);
		r.direct_is_leaf = 1'($urandom);
		r.direct_target = 16'($urandom);
		r.child_bitmap = {$urandom, $urandom};
		r.leaf_bitmap = {$urandom, $urandom};
		r.leaf_base = 16'($urandom);
		r.child_base = 12'($urandom);
		r.port_value = $urandom;
		return r;
	endfunction

	function automatic req_t mk_lookup(logic [ADDR_W-1:0] addr);
		req_t r;
		r = noise_item(OP_LOOKUP);
		r.address = addr;
		return r;
	endfunction

	function automatic req_t mk_direct(logic [15:0] idx, logic is_leaf, logic [15:0] target);
		req_t r;
		r = noise_item(OP_DIRECT);
		r.entry_index = idx;
		r.direct_is_leaf = is_leaf;
		r.direct_target = target;
		return r;
	endfunction

	function automatic req_t mk_node(logic [15:0] idx, logic [MAP_W-1:0] cmap,
			logic [MAP_W-1:0] lmap, logic [LBASE_W-1:0] lbase, logic [CBASE_W-1:0] cbase);
		req_t r;
		r = noise_item(OP_NODE);
		r.entry_index = idx;
		r.child_bitmap = cmap;
		r.leaf_bitmap = lmap;
		r.leaf_base = lbase;
		r.child_base = cbase;
		return r;
	endfunction

	function automatic req_t mk_leaf(logic [15:0] idx, logic [PORT_W-1:0] port);
		req_t r;
		r = noise_item(OP_LEAF);
		r.entry_index = idx;
		r.port_value = port;
		return r;
	endfunction

	function automatic logic [MAP_W-1:0] rand_map();
		logic [MAP_W-1:0] a;
		a = {$urandom, $urandom};
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return a;
			3: return a & {$urandom, $urandom} & {$urandom, $urandom};
			default: return 64'h1 << $urandom_range(0, 63);
		endcase
	endfunction

	function automatic logic [PORT_W-1:0] rand_port();
		case ($urandom_range(0, 7))
			0: return NO_ROUTE;
			1: return '0;
			default: return $urandom;
		endcase
	endfunction

	// small values half the time so that entries get shared
	function automatic logic [15:0] rand_index16();
		return $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 63));
	endfunction

	function automatic req_t rand_node(logic [15:0] idx);
		return mk_node(idx, rand_map(), rand_map(), rand_index16(),
			$urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 31)));
	endfunction

	// drive one transaction and update the shadow state once it is taken
	task automatic send_item(input req_t it, input bit fixed, input logic [PORT_W-1:0] want);
		int                gap;
		route_t            r;
		logic [PORT_W-1:0] p;
		logic [15:0]       mi;
		gap = sender_gaps ? $urandom_range(0, 13) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, it.port_value, it.child_base, it.leaf_base, it.leaf_bitmap,
			it.child_bitmap, it.direct_target, it.direct_is_leaf, it.entry_index,
			it.address};
		s_tuser <= it.op;
		do @(posedge clk); while (s_tready !== 1'b1);
		if (it.op == OP_LOOKUP) begin
			if (fixed) begin
				r.port = want;
			end else begin
				void'(walk_route(it.address, p, mi));
				r.port = p;
			end
			r.found = (r.port != NO_ROUTE);
			route_q.push_back(r);
		end else begin
			apply_write(it);
		end
		if (!(it.op == OP_NODE && it.entry_index >= NODES)) begin
			item_count++;
		end
	endtask

	// write whatever the walk of this address still lacks, then look it up
	task automatic lookup_with_path(input logic [ADDR_W-1:0] addr);
		logic [PORT_W-1:0] p;
		logic [15:0]       mi;
		op_t               kind;
		kind = walk_route(addr, p, mi);
		while (kind != OP_LOOKUP) begin
			case (kind)
				OP_DIRECT: send_item(mk_direct({4'($urandom), mi[11:0]}, 1'($urandom),
					rand_index16()), 1'b0, '0);
				OP_NODE: send_item(rand_node(mi), 1'b0, '0);
				default: send_item(mk_leaf(mi, rand_port()), 1'b0, '0);
			endcase
			kind = walk_route(addr, p, mi);
		end
		send_item(mk_lookup(addr), 1'b0, '0);
	endtask

	function automatic void add_row(req_t it, bit fixed, logic [PORT_W-1:0] want);
		opening_row_t row;
		row.item = it;
		row.fixed = fixed;
		row.want = want;
		opening_rows.push_back(row);
	endfunction

	// receiver: random stalls, one long hold-off on request, in-order check
	initial begin
		int     n;
		int     results;
		bit     stalls;
		route_t r;
		m_tready <= 1'b0;
		results = 0;
		stalls = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			n = stalls ? $urandom_range(0, 13) : 0;
			if (long_hold > 0) begin
				n = long_hold;
				long_hold = 0;
			end
			@(negedge clk);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			if (route_q.size() == 0) begin
				note_mismatch("result with no lookup pending", '0, m_tdata[PORT_W-1:0]);
			end else begin
				r = route_q.pop_front();
				if (m_tdata[PORT_W-1:0] !== r.port) begin
					note_mismatch("port", r.port, m_tdata[PORT_W-1:0]);
				end
				if (m_tdata[PORT_W] !== r.found) begin
					note_mismatch("route_found", 32'(r.found), 32'(m_tdata[PORT_W]));
				end
			end
			results++;
			if (results % 64 == 0) begin
				stalls = $urandom_range(0, 2) != 0;
			end
		end
	end

	// reset, opening rows, random traffic, drain
	initial begin
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] last_addr;
		int                pick;
		int                next_mode_at;
		int                drains;
		bit                held;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_LOOKUP;
		mismatches = 0;
		item_count = 0;
		long_hold = 0;
		sender_gaps = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes: address zero and all ones, no-route leaf, top port value
		add_row(mk_direct(16'h0000, 1'b1, 16'h0000), 1'b0, '0);
		add_row(mk_leaf(16'h0000, 32'h0000_0000), 1'b0, '0);
		add_row(mk_lookup(32'h0000_0000), 1'b1, 32'h0000_0000);
		add_row(mk_leaf(16'hFFFF, NO_ROUTE), 1'b0, '0);
		// direct index beyond the table folds onto its last entry
		add_row(mk_direct(16'hFFFF, 1'b1, 16'hFFFF), 1'b0, '0);
		add_row(mk_lookup(32'hFFFF_FFFF), 1'b1, NO_ROUTE);
		// empty leaf count with zero base wraps to the last leaf
		add_row(mk_direct(16'h0001, 1'b0, 16'h0000), 1'b0, '0);
		add_row(mk_node(16'd0, '0, '0, 16'd0, 12'd0), 1'b0, '0);
		add_row(mk_lookup(32'h0010_0000), 1'b1, NO_ROUTE);
		// full four-level descent, then stop once the stride is past bit 31
		add_row(mk_leaf(16'd100, 32'h0000_ABCD), 1'b0, '0);
		add_row(mk_direct(16'h0002, 1'b0, 16'd63), 1'b0, '0);
		add_row(mk_node(16'd63, '1, '1, 16'd100, 12'd0), 1'b0, '0);
		add_row(mk_node(16'd48, '0, '1, 16'd100, 12'd0), 1'b0, '0);
		add_row(mk_lookup(32'h002F_FFFF), 1'b0, '0);
		// child base at the top wraps the node index to zero
		add_row(mk_direct(16'h0003, 1'b0, 16'd2), 1'b0, '0);
		add_row(mk_node(16'd2, 64'h3, '0, 16'd0, 12'hFFF), 1'b0, '0);
		add_row(mk_lookup(32'h0030_4000), 1'b0, '0);
		// node write beyond the store is dropped
		add_row(mk_node(16'hF000, '1, '1, 16'h1234, 12'h001), 1'b0, '0);
		add_row(mk_lookup(32'h0010_0000), 1'b1, NO_ROUTE);
		add_row(mk_leaf(16'd1, 32'hFFFF_FFFE), 1'b0, '0);
		add_row(mk_direct(16'h0004, 1'b1, 16'd1), 1'b0, '0);
		add_row(mk_lookup(32'h0040_0000), 1'b1, 32'hFFFF_FFFE);
		// overwrite followed at once by a read
		add_row(mk_leaf(16'd0, 32'h1234_5678), 1'b0, '0);
		add_row(mk_lookup(32'h0000_0000), 1'b0, '0);
		// leaf base at the top wraps the leaf index to zero
		add_row(mk_node(16'd2, 64'h3, 64'h3, 16'hFFFF, 12'hFFF), 1'b0, '0);
		add_row(mk_lookup(32'h0030_8000), 1'b0, '0);
		foreach (opening_rows[i]) begin
			send_item(opening_rows[i].item, opening_rows[i].fixed, opening_rows[i].want);
		end

		// random traffic, mostly lookups over paths filled in on demand
		item_count = 0;
		next_mode_at = 100;
		drains = 0;
		held = 1'b0;
		last_addr = $urandom;
		while (item_count < 1450) begin
			if (item_count >= next_mode_at) begin
				sender_gaps = $urandom_range(0, 2) != 0;
				next_mode_at += 100;
			end
			// long receiver hold-off while the sender keeps pushing
			if (!held && item_count >= 400) begin
				held = 1'b1;
				long_hold = 200;
				sender_gaps = 1'b0;
				next_mode_at = item_count + 300;
			end
			// let the pipeline run dry before going on
			if (drains < 2 && item_count >= 700 + 400 * drains) begin
				drains++;
				@(negedge clk);
				s_tvalid <= 1'b0;
				while (route_q.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 19);
			if (pick < 12) begin
				case ($urandom_range(0, 3))
					0: addr = $urandom;
					1: addr = {12'($urandom_range(0, 15)), 20'($urandom)};
					2: addr = last_addr ^ (32'h1 << $urandom_range(0, 19));
					default: addr = {12'($urandom), $urandom_range(0, 1) ? 20'hF_FFFF : 20'h0};
				endcase
				last_addr = addr;
				lookup_with_path(addr);
			end else if (pick < 14) begin
				send_item(mk_direct(16'($urandom), 1'($urandom), rand_index16()), 1'b0, '0);
			end else if (pick < 16) begin
				send_item(rand_node(16'($urandom_range(0, NODES - 1))), 1'b0, '0);
			end else if (pick < 18) begin
				send_item(mk_leaf(16'($urandom), rand_port()), 1'b0, '0);
			end else begin
				send_item(rand_node(16'($urandom_range(NODES, 65535))), 1'b0, '0);
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (route_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/prl_pkg.sv
design/poptrie_route_lookup_top.sv
sim/poptrie_route_lookup_top_tb.sv
